@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ design/ppa_pkg.sv @@
package ppa_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int MAX_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int          CFG_W           = 32;
	localparam logic [7:0] STEAL_BATCH_RST = 8'd64;

	typedef enum logic [1:0] {
		REG_REGION_START = 2'd0,
		REG_REGION_END   = 2'd1,
		REG_STEAL_BATCH  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_FREE  = 1'b0,
		CMD_ALLOC = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OOM      = 2'd1,
		STATUS_BAD_ADDR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_ALLOC,
		ST_SCAN,
		ST_MOVE,
		ST_WB,
		ST_POP,
		ST_DONE
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [2:0]  cpu_id;
		logic [31:0] page_address;
	} req_t;

	typedef struct packed {
		logic [31:0] granted_address;
		status_t     status;
		logic [7:0]  pages_stolen;
	} rsp_t;

	typedef struct packed {
		logic [31:0] region_start;
		logic [31:0] region_end;
		logic [7:0]  steal_batch;
	} cfg_t;

	// cpu_id modulo n, by repeated subtraction on a 3-bit value
	function automatic logic [6:0] cpu_wrap(input logic [2:0] id, input int unsigned n);
		logic [6:0] v;
		v = {4'b0, id};
		for (int k = 0; k < 8; k++) begin
			if (v >= 7'(n)) begin
				v = v - 7'(n);
			end
		end
		return v;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

endpackage

@@ design/ppa_ram.sv @@
module ppa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [AW-1:0]            raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ design/ppa_ctrl.sv @@
`include "assert_macros.svh"

module ppa_ctrl #(
	parameter int NUM_CPUS   = ppa_pkg::NUM_CPUS_DEF,
	parameter int MAX_PAGES  = ppa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = ppa_pkg::PAGE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ppa_pkg::cfg_t cfg,
	input  logic          req_valid,
	output logic          req_ready,
	input  ppa_pkg::req_t req,
	output logic          done_valid,
	input  logic          done_ready,
	output ppa_pkg::rsp_t rsp
);

	localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int VIC_W = CPU_W + 1;
	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int PG_SH = $clog2(PAGE_BYTES);
	localparam int PG_W  = 32 - PG_SH;

	ppa_pkg::state_t state_q, state_d;

	ppa_pkg::cmd_t  cmd_q;
	logic [CPU_W-1:0] cpu_q;
	logic [31:0]      addr_q;
	logic [7:0]       budget_q;
	logic [7:0]       stolen_q;
	logic [VIC_W-1:0] vic_q;
	logic [IDX_W-1:0] own_head_q;
	logic [31:0]      own_cnt_q;
	ppa_pkg::rsp_t    rsp_q;

	logic [IDX_W-1:0] head_q [NUM_CPUS];
	logic [31:0]      cnt_q  [NUM_CPUS];

	logic [CPU_W-1:0] t_idx;
	logic [IDX_W-1:0] t_head;
	logic [31:0]      t_cnt;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_head_d;
	logic [31:0]      tbl_cnt_d;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [IDX_W-1:0] ram_rdata;

	logic             own_ld;
	logic             mv;
	logic             vic_inc;
	logic             rsp_ld;
	ppa_pkg::rsp_t    rsp_d;

	logic [PG_W-1:0]  base_pg;
	logic [PG_W-1:0]  pg_off;
	logic [IDX_W-1:0] free_idx;
	logic             free_ok;
	logic [PG_W-1:0]  grant_pg;
	logic [31:0]      vic_dec;
	logic [31:0]      own_dec;
	logic             accept;

	assign accept = req_valid && req_ready;

	assign t_idx  = (state_q == ppa_pkg::ST_SCAN || state_q == ppa_pkg::ST_MOVE) ?
		vic_q[CPU_W-1:0] : cpu_q;
	assign t_head = head_q[t_idx];
	assign t_cnt  = cnt_q[t_idx];

	assign base_pg  = cfg.region_start[31:PG_SH];
	assign pg_off   = addr_q[31:PG_SH] - base_pg;
	assign free_idx = IDX_W'(pg_off);
	assign free_ok  = (addr_q[PG_SH-1:0] == '0) && (addr_q >= cfg.region_start) &&
		(addr_q < cfg.region_end) && ({{PG_SH{1'b0}}, pg_off} < 32'(MAX_PAGES));
	assign grant_pg = PG_W'(own_head_q) + base_pg;
	assign vic_dec  = t_cnt - 32'd1;
	assign own_dec  = own_cnt_q - 32'd1;

	assign ram_raddr = (state_q == ppa_pkg::ST_WB) ? own_head_q : t_head;

	ppa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_PAGES)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		done_valid = 1'b0;
		tbl_we     = 1'b0;
		tbl_head_d = t_head;
		tbl_cnt_d  = t_cnt;
		ram_we     = 1'b0;
		ram_waddr  = t_head;
		ram_wdata  = own_head_q;
		own_ld     = 1'b0;
		mv         = 1'b0;
		vic_inc    = 1'b0;
		rsp_ld     = 1'b0;
		rsp_d      = '{granted_address: '0, status: ppa_pkg::STATUS_OK, pages_stolen: '0};
		case (state_q)
			ppa_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (req.command == ppa_pkg::CMD_FREE) ?
						ppa_pkg::ST_FREE : ppa_pkg::ST_ALLOC;
				end
			end
			ppa_pkg::ST_FREE: begin
				rsp_ld = 1'b1;
				if (free_ok) begin
					tbl_we     = 1'b1;
					tbl_head_d = free_idx;
					tbl_cnt_d  = ppa_pkg::sat_inc(t_cnt);
					ram_we     = 1'b1;
					ram_waddr  = free_idx;
					ram_wdata  = t_head;
				end else begin
					rsp_d.status = ppa_pkg::STATUS_BAD_ADDR;
				end
				state_d = ppa_pkg::ST_DONE;
			end
			ppa_pkg::ST_ALLOC: begin
				own_ld  = 1'b1;
				state_d = (t_cnt != '0) ? ppa_pkg::ST_POP : ppa_pkg::ST_SCAN;
			end
			ppa_pkg::ST_SCAN: begin
				if (budget_q == '0 || vic_q == VIC_W'(NUM_CPUS)) begin
					state_d = ppa_pkg::ST_WB;
				end else if (vic_q[CPU_W-1:0] == cpu_q || t_cnt == '0) begin
					vic_inc = 1'b1;
				end else begin
					state_d = ppa_pkg::ST_MOVE;
				end
			end
			ppa_pkg::ST_MOVE: begin
				// pop victim head, push it on the requester's cached list
				mv         = 1'b1;
				tbl_we     = 1'b1;
				tbl_cnt_d  = vic_dec;
				tbl_head_d = (vic_dec != '0) ? ram_rdata : t_head;
				ram_we     = 1'b1;
				ram_waddr  = t_head;
				ram_wdata  = own_head_q;
				state_d    = ppa_pkg::ST_SCAN;
			end
			ppa_pkg::ST_WB: begin
				tbl_we     = 1'b1;
				tbl_head_d = own_head_q;
				tbl_cnt_d  = own_cnt_q;
				if (own_cnt_q != '0) begin
					state_d = ppa_pkg::ST_POP;
				end else begin
					rsp_ld             = 1'b1;
					rsp_d.status       = ppa_pkg::STATUS_OOM;
					rsp_d.pages_stolen = stolen_q;
					state_d            = ppa_pkg::ST_DONE;
				end
			end
			ppa_pkg::ST_POP: begin
				tbl_we     = 1'b1;
				tbl_cnt_d  = own_dec;
				tbl_head_d = (own_dec != '0) ? ram_rdata : own_head_q;
				rsp_ld     = 1'b1;
				rsp_d.granted_address = {grant_pg, {PG_SH{1'b0}}};
				rsp_d.pages_stolen    = stolen_q;
				state_d    = ppa_pkg::ST_DONE;
			end
			ppa_pkg::ST_DONE: begin
				done_valid = 1'b1;
				if (done_ready) begin
					state_d = ppa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			budget_q <= '0;
			stolen_q <= '0;
			vic_q    <= '0;
		end else begin
			if (tbl_we) begin
				head_q[t_idx] <= tbl_head_d;
				cnt_q[t_idx]  <= tbl_cnt_d;
			end
			if (accept) begin
				budget_q <= cfg.steal_batch;
				stolen_q <= '0;
				vic_q    <= '0;
			end else begin
				if (mv) begin
					budget_q <= budget_q - 8'd1;
					stolen_q <= stolen_q + 8'd1;
				end
				if (vic_inc) begin
					vic_q <= vic_q + VIC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			cpu_q  <= CPU_W'(ppa_pkg::cpu_wrap(req.cpu_id, NUM_CPUS));
			addr_q <= req.page_address;
		end
		if (own_ld) begin
			own_head_q <= t_head;
			own_cnt_q  <= t_cnt;
		end else if (mv) begin
			own_head_q <= t_head;
			own_cnt_q  <= ppa_pkg::sat_inc(own_cnt_q);
		end
		if (rsp_ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	`ASSERT_CHK(a_alloc_path, clk, arst_n,
		(state_q == ppa_pkg::ST_ALLOC) |-> (cmd_q == ppa_pkg::CMD_ALLOC),
		"allocate sequence entered for a free")
	`ASSERT_CHK(a_pop_nonempty, clk, arst_n,
		(state_q == ppa_pkg::ST_POP) |-> (own_cnt_q != '0),
		"pop from an empty list")
	`ASSERT_CHK(a_move_victim, clk, arst_n,
		(state_q == ppa_pkg::ST_MOVE) |-> ($past(state_q) == ppa_pkg::ST_SCAN &&
		vic_q != VIC_W'(NUM_CPUS) && vic_q[CPU_W-1:0] != cpu_q),
		"steal from requester or past last cpu")
	`ASSERT_CHK(a_stolen_mono, clk, arst_n,
		(state_q != ppa_pkg::ST_IDLE && $past(state_q) != ppa_pkg::ST_IDLE) |->
		(stolen_q >= $past(stolen_q)),
		"stolen count went backwards")

endmodule

@@ design/per_cpu_page_allocator_core.sv @@
// Per-CPU page allocator: one LIFO free list per CPU, linked through a link RAM of
// MAX_PAGES entries. A free runs FREE then DONE; an allocate that finds pages on its
// own list runs ALLOC, POP, DONE. An allocate on an empty list first steals from the
// other CPUs in ascending order: a SCAN per CPU looked at, plus one when the scan runs
// past the last CPU, a SCAN and a MOVE per page moved (the registered read of the link
// RAM sets this), WB to write the list back, then the pop or an OOM result. One item
// is in work at a time; the result register lets the next item in while a result
// waits. The link RAM is not cleared after reset. PAGE_BYTES must be a power of two.
// The user must write registers only while the block is idle; it does not check this.
module per_cpu_page_allocator_core #(
	parameter int NUM_CPUS   = ppa_pkg::NUM_CPUS_DEF,
	parameter int MAX_PAGES  = ppa_pkg::MAX_PAGES_DEF,
	parameter int PAGE_BYTES = ppa_pkg::PAGE_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  ppa_pkg::cfg_reg_t         cfg_index,
	input  logic [ppa_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  ppa_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output ppa_pkg::rsp_t             rsp
);

	ppa_pkg::cfg_t cfg_q;
	ppa_pkg::rsp_t rsp_q;
	ppa_pkg::rsp_t done_rsp;
	logic          rsp_valid_q;
	logic          done_valid;
	logic          done_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_start <= '0;
			cfg_q.region_end   <= '0;
			cfg_q.steal_batch  <= ppa_pkg::STEAL_BATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ppa_pkg::REG_REGION_START: cfg_q.region_start <= cfg_wdata;
				ppa_pkg::REG_REGION_END:   cfg_q.region_end   <= cfg_wdata;
				ppa_pkg::REG_STEAL_BATCH:  cfg_q.steal_batch  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	ppa_ctrl #(
		.NUM_CPUS  (NUM_CPUS),
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.done_valid(done_valid),
		.done_ready(done_ready),
		.rsp       (done_rsp)
	);

	// result beat register
	assign done_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			rsp_q <= done_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ sim/tb_per_cpu_page_allocator_core.sv @@
`timescale 1ns / 1ps

module tb_per_cpu_page_allocator_core;

	localparam int PAGE  = ppa_pkg::PAGE_BYTES_DEF;
	localparam int CPUS  = ppa_pkg::NUM_CPUS_DEF;
	localparam int PAGES = ppa_pkg::MAX_PAGES_DEF;
	localparam int LIMIT = 1_500_000;

	class page_ledger;
		logic [31:0]   region_start;
		logic [31:0]   region_end;
		logic [7:0]    steal_batch;
		logic [15:0]   link_ram [PAGES];
		logic [15:0]   head [CPUS];
		logic [31:0]   depth [CPUS];
		ppa_pkg::rsp_t due_grants [$];
		int            mismatches;

		function new();
			region_start = '0;
			region_end   = '0;
			steal_batch  = ppa_pkg::STEAL_BATCH_RST;
			for (int i = 0; i < CPUS; i++) begin
				head[i]  = '0;
				depth[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void set_reg(ppa_pkg::cfg_reg_t idx, logic [31:0] val);
			case (idx)
			ppa_pkg::REG_REGION_START: region_start = val;
			ppa_pkg::REG_REGION_END:   region_end = val;
			ppa_pkg::REG_STEAL_BATCH:  steal_batch = val[7:0];
			default: ;
			endcase
		endfunction

		function void push_page(int c, logic [15:0] idx);
			link_ram[idx] = head[c];
			head[c] = idx;
			if (depth[c] != '1)
				depth[c]++;
		endfunction

		function logic [15:0] pop_page(int c);
			logic [15:0] idx;
			idx = head[c];
			depth[c]--;
			if (depth[c] != 0)
				head[c] = link_ram[idx];
			return idx;
		endfunction

		function void note_request(ppa_pkg::req_t r);
			ppa_pkg::rsp_t exp;
			int            c;
			int            budget;
			logic [31:0]   base;
			logic [31:0]   pg;
			logic [15:0]   idx;
			logic [7:0]    stolen;
			bit            ok;
			exp    = '0;
			stolen = '0;
			c      = int'(r.cpu_id) % CPUS;
			base   = region_start / PAGE;
			if (r.command == ppa_pkg::CMD_FREE) begin
				ok = (r.page_address % PAGE == 0) && r.page_address >= region_start
					&& r.page_address < region_end;
				pg = r.page_address / PAGE - base;
				if (ok && pg >= PAGES)
					ok = 0;
				if (ok)
					push_page(c, pg[15:0]);
				else
					exp.status = ppa_pkg::STATUS_BAD_ADDR;
			end else begin
				if (depth[c] == 0) begin
					budget = steal_batch;
					for (int i = 0; i < CPUS && budget != 0; i++) begin
						while (i != c && depth[i] != 0 && budget != 0) begin
							push_page(c, pop_page(i));
							budget--;
							stolen++;
						end
					end
				end
				if (depth[c] != 0) begin
					idx = pop_page(c);
					exp.granted_address = 32'((64'(idx) + 64'(base)) * PAGE);
				end else begin
					exp.status = ppa_pkg::STATUS_OOM;
				end
			end
			exp.pages_stolen = stolen;
			due_grants.push_back(exp);
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_grant(ppa_pkg::rsp_t got);
			ppa_pkg::rsp_t exp;
			if (due_grants.size() == 0) begin
				report($sformatf("beat with nothing due: %h", got));
			end else begin
				exp = due_grants.pop_front();
				if (got.granted_address !== exp.granted_address)
					report($sformatf("granted_address %h, due %h",
						got.granted_address, exp.granted_address));
				if (got.status !== exp.status)
					report($sformatf("status %0d, due %0d", got.status, exp.status));
				if (got.pages_stolen !== exp.pages_stolen)
					report($sformatf("pages_stolen %0d, due %0d",
						got.pages_stolen, exp.pages_stolen));
			end
		endtask

		task check_drained();
			if (due_grants.size() != 0)
				report($sformatf("%0d beats never arrived", due_grants.size()));
		endtask

		function int outstanding();
			return due_grants.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	ppa_pkg::cfg_reg_t         cfg_index = ppa_pkg::REG_REGION_START;
	logic [ppa_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	ppa_pkg::req_t             req = '0;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	ppa_pkg::rsp_t             rsp;

	int                send_idle_pct = 10;
	int                recv_idle_pct = 53;
	int                stall_left = 0;
	int unsigned       cycles = 0;
	logic [31:0]       cur_start = '0;
	logic [31:0]       cur_end = '0;
	page_ledger        book;

	per_cpu_page_allocator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_per_cpu_page_allocator_core: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			book.note_request(req);
		if (arst_n && rsp_valid && rsp_ready)
			book.check_grant(rsp);
	end

	// receiver; a long hold-off is counted down here
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_op(ppa_pkg::cmd_t cmd, int cpu, logic [31:0] addr);
		ppa_pkg::req_t r;
		r.command      = cmd;
		r.cpu_id       = 3'(cpu);
		r.page_address = addr;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		int            roll;
		int unsigned   n;
		int unsigned   k;
		logic [63:0]   first;
		logic [31:0]   addr;
		ppa_pkg::cmd_t cmd;
		roll  = $urandom_range(0, 99);
		addr  = $urandom;
		cmd   = ppa_pkg::CMD_FREE;
		first = (64'(cur_start) + 64'(PAGE - 1)) & ~64'(PAGE - 1);
		if (roll < 42) begin
			cmd = ppa_pkg::CMD_ALLOC;
		end else if (roll < 88 && first < 64'(cur_end)) begin
			n = 32'((64'(cur_end) - first + 64'(PAGE - 1)) / PAGE);
			if (roll < 84)
				k = $urandom_range(0, (n < 48 ? n : 48) - 1);
			else
				k = n - 1 - $urandom_range(0, (n < 4 ? n : 4) - 1);
			addr = 32'(first + 64'(k) * PAGE);
		end else if (roll < 94) begin
			case ($urandom_range(0, 2))
			0: addr = cur_start - PAGE;
			1: addr = cur_end;
			default: addr = cur_start + $urandom_range(1, PAGE - 1);
			endcase
		end
		send_op(cmd, $urandom_range(0, CPUS - 1), addr);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (book.outstanding() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_regs(logic [31:0] start, logic [31:0] lim, logic [7:0] batch);
		cfg_we    <= 1'b1;
		cfg_index <= ppa_pkg::REG_REGION_START;
		cfg_wdata <= start;
		@(negedge clk);
		cfg_index <= ppa_pkg::REG_REGION_END;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_index <= ppa_pkg::REG_STEAL_BATCH;
		cfg_wdata <= ppa_pkg::CFG_W'(batch);
		@(negedge clk);
		cfg_we <= 1'b0;
		book.set_reg(ppa_pkg::REG_REGION_START, start);
		book.set_reg(ppa_pkg::REG_REGION_END, lim);
		book.set_reg(ppa_pkg::REG_STEAL_BATCH, ppa_pkg::CFG_W'(batch));
		cur_start = start;
		cur_end   = lim;
	endtask

	initial begin
		logic [31:0] rs;
		logic [31:0] re;
		book = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: empty region, empty lists
		send_op(ppa_pkg::CMD_FREE, 0, 32'h0000_0000);
		send_op(ppa_pkg::CMD_ALLOC, 0, 32'h0000_0000);
		settle();

		program_regs(32'h8000_0000, 32'hFFFF_F000, 8'd255);
		send_op(ppa_pkg::CMD_FREE, 0, 32'h8000_0001);
		send_op(ppa_pkg::CMD_FREE, 1, 32'h7FFF_F000);
		send_op(ppa_pkg::CMD_FREE, 2, 32'hFFFF_F000);
		send_op(ppa_pkg::CMD_FREE, 3, 32'h8800_0000);
		send_op(ppa_pkg::CMD_FREE, 4, 32'hFFFF_FFFF);
		send_op(ppa_pkg::CMD_FREE, 0, 32'h87FF_F000);
		send_op(ppa_pkg::CMD_FREE, 7, 32'h8000_0000);
		send_op(ppa_pkg::CMD_FREE, 3, 32'h8000_1000);
		send_op(ppa_pkg::CMD_FREE, 3, 32'h8000_1000);
		send_op(ppa_pkg::CMD_ALLOC, 7, 32'hFFFF_FFFF);
		send_op(ppa_pkg::CMD_ALLOC, 7, 32'h0000_0000);
		send_op(ppa_pkg::CMD_ALLOC, 7, 32'h0000_0000);
		send_op(ppa_pkg::CMD_ALLOC, 7, 32'h0000_0000);
		send_op(ppa_pkg::CMD_ALLOC, 7, 32'h0000_0000);
		settle();

		// no stealing, then one page at a time
		program_regs(32'h8000_0000, 32'hFFFF_F000, 8'd0);
		send_op(ppa_pkg::CMD_FREE, 1, 32'h8000_2000);
		send_op(ppa_pkg::CMD_ALLOC, 2, 32'h0000_0000);
		settle();
		program_regs(32'h8000_0000, 32'hFFFF_F000, 8'd1);
		send_op(ppa_pkg::CMD_ALLOC, 2, 32'h0000_0000);
		send_op(ppa_pkg::CMD_FREE, 5, 32'h8000_3000);
		settle();

		// base moves with a page still listed
		program_regs(32'h8000_1000, 32'hFFFF_F000, 8'd1);
		send_op(ppa_pkg::CMD_ALLOC, 5, 32'h0000_0000);

		for (int p = 0; p < 6; p++) begin
			settle();
			case (p)
			0: program_regs(32'h0000_0000, 32'h0800_0000, 8'd64);
			1: program_regs(32'h8000_0000, 32'hFFFF_FFFF, 8'd255);
			2: program_regs(32'hFFFF_F000, 32'hFFFF_FFFF, 8'd1);
			3: program_regs(32'h0000_0800, 32'h0010_0000, 8'd0);
			4: begin
				rs = $urandom & 32'hFFFF_F000;
				re = (rs > 32'hFF00_0000) ? 32'hFFFF_FFFF : rs + $urandom_range(1, 32'h0100_0000);
				program_regs(rs, re, 8'($urandom_range(1, 255)));
			end
			default: program_regs(32'h0000_1000, 32'h0004_1000, 8'd2);
			endcase
			if (p < 2) begin
				send_idle_pct = 10;
				recv_idle_pct = 53;
			end else if (p < 4) begin
				send_idle_pct = 53;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0)
				stall_left = 400;
			repeat (85) send_random();
		end

		settle();
		repeat (20) @(negedge clk);
		book.check_drained();
		if (book.mismatches == 0)
			$display("tb_per_cpu_page_allocator_core: done, clean");
		else
			$display("tb_per_cpu_page_allocator_core: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/ppa_pkg.sv
design/ppa_ram.sv
design/ppa_ctrl.sv
design/per_cpu_page_allocator_core.sv
sim/tb_per_cpu_page_allocator_core.sv
